// ===== hdl/luhn_pkg.sv =====
// ----------------------------------------------------------------------------
// Luhn check and card brand package
// Widths, brand codes, leading-digit constants and helper functions that the
// controller, the datapath and the top level share.
// ----------------------------------------------------------------------------
package luhn_pkg;

  // Card number width and digit limits.
  localparam int CARD_W        = 63;
  localparam int MAX_DIGITS    = 19;
  // A 63-bit value always fits in nineteen decimal digits.
  localparam int DEC_DIGITS    = 19;
  localparam int BCD_W         = 4 * DEC_DIGITS;
  localparam int BITS_PER_STEP = 3;
  localparam int CONV_STEPS    = CARD_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS + 1);
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);

  // Brand codes.
  typedef enum logic [1:0] {
    BRAND_INVALID    = 2'd0,
    BRAND_AMEX       = 2'd1,
    BRAND_MASTERCARD = 2'd2,
    BRAND_VISA       = 2'd3
  } brand_e;

  // Leading digits, kept in BCD form.
  localparam logic [7:0] LEAD_AMEX_A = 8'h34;
  localparam logic [7:0] LEAD_AMEX_B = 8'h37;
  localparam logic [7:0] LEAD_MC_LO  = 8'h51;
  localparam logic [7:0] LEAD_MC_HI  = 8'h55;
  localparam logic [3:0] LEAD_VISA   = 4'd4;

  // Card lengths.
  localparam logic [CNT_W-1:0] LEN_AMEX     = CNT_W'(15);
  localparam logic [CNT_W-1:0] LEN_16       = CNT_W'(16);
  localparam logic [CNT_W-1:0] LEN_VISA_OLD = CNT_W'(13);
  localparam logic [CNT_W-1:0] LEN_MAX      = CNT_W'(MAX_DIGITS);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic conv;
    logic walk;
    logic publish;
  } luhn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
  } luhn_stat_t;

  // Digit sum of a doubled decimal digit.
  function automatic logic [3:0] doubled_digit_sum(input logic [3:0] d);
    logic [4:0] p;
    p = {d, 1'b0};
    doubled_digit_sum = (p > 5'd9) ? 4'(p - 5'd9) : p[3:0];
  endfunction

  function automatic brand_e classify(input logic ok, input logic [CNT_W-1:0] count,
                                     input logic [3:0] lead1, input logic [7:0] lead2);
    brand_e b;
    b = BRAND_INVALID;
    if (ok) begin
      if ((count == LEN_AMEX) && ((lead2 == LEAD_AMEX_A) || (lead2 == LEAD_AMEX_B))) begin
        b = BRAND_AMEX;
      end else if ((count == LEN_16) && (lead2 >= LEAD_MC_LO) && (lead2 <= LEAD_MC_HI)) begin
        b = BRAND_MASTERCARD;
      end else if (((count == LEN_VISA_OLD) || (count == LEN_16)) && (lead1 == LEAD_VISA)) begin
        b = BRAND_VISA;
      end
    end
    classify = b;
  endfunction

endpackage

// ===== hdl/luhn_ctrl.sv =====
// ----------------------------------------------------------------------------
// Luhn check controller
// Sequences binary-to-BCD conversion and the digit walk, and owns the output
// valid flag.
// ----------------------------------------------------------------------------
module luhn_ctrl import luhn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  luhn_stat_t stat_i,
  output luhn_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_cnt_q, step_cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              slot_free;
  logic              in_accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  // The output register can take a new result when empty or being drained.
  assign slot_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    step_cnt_d = step_cnt_q;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_o.load = 1'b1;
          step_cnt_d = '0;
          state_d    = S_CONV;
        end
      end
      S_CONV: begin
        cmd_o.conv = 1'b1;
        step_cnt_d = step_cnt_q + 1'b1;
        if (step_cnt_q == STEP_W'(CONV_STEPS - 1)) begin
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (!stat_i.walk_done) begin
          cmd_o.walk = 1'b1;
        end else if (slot_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      S_HOLD: begin
        if (slot_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_cnt_q  <= step_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result is never written over one that is still waiting.
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || !out_stall_i))
    else $error("result published into an occupied output register");

  a_conv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> (step_cnt_q < STEP_W'(CONV_STEPS)))
    else $error("conversion counter out of range");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_CONV) && (step_cnt_q == '0))
    else $error("accepted transaction did not start conversion");

endmodule

// ===== hdl/luhn_dp.sv =====
// ----------------------------------------------------------------------------
// Luhn check datapath
// Converts the card number to BCD three bits per cycle, then walks the digits
// from the least significant end, one per cycle, and holds the result.
// ----------------------------------------------------------------------------
module luhn_dp import luhn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CARD_W-1:0] card_value_i,
  input  luhn_cmd_t         cmd_i,
  output luhn_stat_t        stat_o,
  output logic [1:0]        brand_o,
  output logic              luhn_ok_o,
  output logic [CNT_W-1:0]  digit_total_o
);

  logic [CARD_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]  bcd_q, bcd_d;
  logic [3:0]        sum_q, sum_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [3:0]        lead1_q, lead1_d;
  logic [7:0]        lead2_q, lead2_d;
  logic              odd_q, odd_d;
  logic [1:0]        brand_q;
  logic              luhn_ok_q;
  logic [CNT_W-1:0]  digit_total_q;

  logic [BCD_W-1:0]  conv_bcd;
  logic [CARD_W-1:0] conv_bin;
  logic [3:0]        digit;
  logic [3:0]        addend;
  logic [4:0]        sum_raw;
  logic [3:0]        sum_next;

  // Shift-and-add-3 conversion, several bit steps per cycle.
  always_comb begin
    conv_bcd = bcd_q;
    conv_bin = bin_q;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      for (int j = 0; j < DEC_DIGITS; j++) begin
        if (conv_bcd[4*j +: 4] >= 4'd5) begin
          conv_bcd[4*j +: 4] = conv_bcd[4*j +: 4] + 4'd3;
        end
      end
      conv_bcd = {conv_bcd[BCD_W-2:0], conv_bin[CARD_W-1]};
      conv_bin = {conv_bin[CARD_W-2:0], 1'b0};
    end
  end

  assign digit    = bcd_q[3:0];
  assign addend   = odd_q ? digit : doubled_digit_sum(digit);
  assign sum_raw  = {1'b0, sum_q} + {1'b0, addend};
  // The sum is kept modulo ten.
  assign sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

  assign stat_o.walk_done = (bcd_q == '0) || (count_q == LEN_MAX);

  always_comb begin
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    sum_d   = sum_q;
    count_d = count_q;
    lead1_d = lead1_q;
    lead2_d = lead2_q;
    odd_d   = odd_q;
    if (cmd_i.load) begin
      bin_d   = card_value_i;
      bcd_d   = '0;
      sum_d   = '0;
      count_d = '0;
      lead1_d = '0;
      lead2_d = '0;
      odd_d   = 1'b1;
    end else if (cmd_i.conv) begin
      bin_d = conv_bin;
      bcd_d = conv_bcd;
    end else if (cmd_i.walk) begin
      if (bcd_q[BCD_W-1:4] == '0) begin
        lead1_d = digit;
      end else if (bcd_q[BCD_W-1:8] == '0) begin
        lead2_d = bcd_q[7:0];
      end
      sum_d   = sum_next;
      odd_d   = !odd_q;
      count_d = count_q + 1'b1;
      bcd_d   = {4'd0, bcd_q[BCD_W-1:4]};
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    sum_q   <= sum_d;
    count_q <= count_d;
    lead1_q <= lead1_d;
    lead2_q <= lead2_d;
    odd_q   <= odd_d;
    if (cmd_i.publish) begin
      brand_q       <= classify(sum_q == 4'd0, count_q, lead1_q, lead2_q);
      luhn_ok_q     <= (sum_q == 4'd0);
      digit_total_q <= count_q;
    end
  end

  assign brand_o       = brand_q;
  assign luhn_ok_o     = luhn_ok_q;
  assign digit_total_o = digit_total_q;

  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (sum_q < 4'd10))
    else $error("running digit sum left the range of one decimal digit");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (count_q < LEN_MAX))
    else $error("digit walk ran past the digit limit");

  a_brand_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> (brand_q == BRAND_INVALID) || luhn_ok_q)
    else $error("brand reported for a number that fails the check");

endmodule

// ===== hdl/luhn_card_brand_check_unit.sv =====
// ----------------------------------------------------------------------------
// Luhn check and card brand unit
// Checks the Luhn digit sum of a binary card number and classifies its brand.
//
// The input channel carries one card number per transaction (in_valid_i,
// in_stall_o, card_value_i). The output channel returns one transaction per
// number with brand_o, luhn_ok_o and digit_total_o, held in an output register
// under out_valid_o and out_stall_i.
// Each number is converted to BCD three bits per cycle, then its
// digits are walked one per cycle from the least significant end. The result
// is registered once the walk ends and the output register is free; the unit
// takes no new number until then, since the BCD converter and the single
// digit accumulator serve one number at a time.
// A new number may be accepted while the previous result still waits; if the
// receiver stalls and the next result is finished, the unit holds it and keeps
// in_stall_o high until the output register drains.
// Reset clears the controller and the output valid flag; the unit is ready for
// a number in the first cycle after reset.
// ----------------------------------------------------------------------------
module luhn_card_brand_check_unit import luhn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CARD_W-1:0] card_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        brand_o,
  output logic              luhn_ok_o,
  output logic [CNT_W-1:0]  digit_total_o
);

  luhn_cmd_t  cmd;
  luhn_stat_t stat;

  luhn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  luhn_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .card_value_i  (card_value_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .brand_o       (brand_o),
    .luhn_ok_o     (luhn_ok_o),
    .digit_total_o (digit_total_o)
  );

endmodule
